// ----- hdl/integer_to_ascii_radix_core_macros.svh -----
// Assertion macros for the integer-to-ASCII converter checker.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef INTEGER_TO_ASCII_RADIX_CORE_MACROS_SVH
`define INTEGER_TO_ASCII_RADIX_CORE_MACROS_SVH

// Check a property outside of reset.
`define I2A_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check a property at every edge, reset included.
`define I2A_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hdl/i2a_pkg.sv -----
// Shared types and constants for the integer-to-ASCII converter.
// No dependencies; imported by every module of the block.
`default_nettype none

package i2a_pkg;

  localparam int ValueW    = 64;
  localparam int NumDigits = 22;
  localparam int DigW      = NumDigits * 4;
  localparam int CharW     = 7;
  localparam int CntW      = $clog2(NumDigits + 1);
  localparam int StepW     = $clog2(ValueW);

  localparam logic [CharW-1:0] CharZero  = 7'h30;
  localparam logic [CharW-1:0] CharNine  = 7'h39;
  localparam logic [CharW-1:0] CharMinus = 7'h2D;

  typedef enum logic [1:0] {
    FUNC_UDEC = 2'd0,
    FUNC_OCT  = 2'd1,
    FUNC_SDEC = 2'd2,
    FUNC_RSVD = 2'd3
  } func_e;

  // One classified number waiting for conversion.
  typedef struct packed {
    logic              octal;
    logic              minus;
    logic [ValueW-1:0] mag;
  } work_t;

endpackage

`default_nettype wire

// ----- hdl/i2a_front.sv -----
// Front end: accepts numbers, classifies mode and sign, queues magnitudes.
// Depends on i2a_pkg.
`default_nettype none

module i2a_front #(
  parameter int Depth = 2
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [1:0]             func_i,
  input  wire logic [63:0]            value_i,
  output logic                        work_valid_o,
  input  wire logic                   work_ready_i,
  output i2a_pkg::work_t              work_o
);
  import i2a_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntQW = $clog2(Depth + 1);

  work_t             mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntQW-1:0]  count_q, count_d;
  work_t             cls;
  logic              push, pop;

  // Classify: negative signed values become their magnitude
  always_comb begin
    cls.octal = (func_e'(func_i) == FUNC_OCT);
    cls.minus = (func_e'(func_i) == FUNC_SDEC) && value_i[ValueW-1];
    cls.mag   = cls.minus ? (~value_i + 64'd1) : value_i;
  end

  assign in_ready_o   = (count_q != CntQW'(Depth));
  assign work_valid_o = (count_q != '0);
  assign work_o       = mem_q[rd_ptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = work_valid_o && work_ready_i;

  // Advance pointers with wrap, track fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the classified entry
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cls;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/i2a_back.sv -----
// Back end: shift-and-add-3 decimal conversion or octal split, then emits
// characters most significant first through an output register. Uses i2a_pkg.
`default_nettype none

module i2a_back (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   work_valid_i,
  output logic                        work_ready_o,
  input  wire i2a_pkg::work_t         work_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [i2a_pkg::CharW-1:0]   ascii_char_o,
  output logic                        last_o
);
  import i2a_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SIGN = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  state_e             state_q, state_d;
  logic [ValueW-1:0]  mag_q, mag_d;
  logic [DigW-1:0]    dig_q, dig_d;
  logic               minus_q, minus_d;
  logic [StepW-1:0]   step_q, step_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               started_q, started_d;
  logic               out_valid_q, out_valid_d;
  logic [CharW-1:0]   char_q;
  logic               last_q;

  logic [DigW-1:0]    oct_dig;
  logic [DigW-1:0]    dabble_dig;
  logic [3:0]         top_dig;
  logic               last_dig;
  logic               out_free;
  logic               emit_en;
  logic [CharW-1:0]   emit_char;
  logic               emit_last;

  // Split the magnitude into 3-bit octal digits, padded to 66 bits
  always_comb begin
    logic [3*NumDigits-1:0] padded;
    padded = (3 * NumDigits)'(work_i.mag);
    for (int j = 0; j < NumDigits; j++) begin
      oct_dig[4*j +: 4] = {1'b0, padded[3*j +: 3]};
    end
  end

  // One double-dabble step: add 3 to digits of five or more, shift in next bit
  always_comb begin
    logic [DigW-1:0] adj;
    for (int j = 0; j < NumDigits; j++) begin
      adj[4*j +: 4] = (dig_q[4*j +: 4] >= 4'd5) ? dig_q[4*j +: 4] + 4'd3
                                                 : dig_q[4*j +: 4];
    end
    dabble_dig = {adj[DigW-2:0], mag_q[ValueW-1]};
  end

  assign top_dig      = dig_q[DigW-1 -: 4];
  assign last_dig     = (cnt_q == CntW'(1));
  assign out_free     = !out_valid_q || out_ready_i;
  assign work_ready_o = (state_q == ST_IDLE);

  // Sequencer: load, convert, optional sign, digit scan with zero skip
  always_comb begin
    state_d   = state_q;
    mag_d     = mag_q;
    dig_d     = dig_q;
    minus_d   = minus_q;
    step_d    = step_q;
    cnt_d     = cnt_q;
    started_d = started_q;
    emit_en   = 1'b0;
    emit_char = CharZero;
    emit_last = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (work_valid_i) begin
          minus_d   = work_i.minus;
          started_d = 1'b0;
          cnt_d     = CntW'(NumDigits);
          step_d    = '0;
          if (work_i.octal) begin
            dig_d   = oct_dig;
            state_d = ST_SIGN;
          end else begin
            mag_d   = work_i.mag;
            dig_d   = '0;
            state_d = ST_CONV;
          end
        end
      end
      ST_CONV: begin
        dig_d  = dabble_dig;
        mag_d  = {mag_q[ValueW-2:0], 1'b0};
        step_d = step_q + 1'b1;
        if (step_q == StepW'(ValueW - 1)) begin
          state_d = ST_SIGN;
        end
      end
      ST_SIGN: begin
        if (!minus_q) begin
          state_d = ST_EMIT;
        end else if (out_free) begin
          emit_en   = 1'b1;
          emit_char = CharMinus;
          state_d   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!started_q && top_dig == 4'd0 && !last_dig) begin
          // drop a leading zero
          dig_d = {dig_q[DigW-5:0], 4'd0};
          cnt_d = cnt_q - 1'b1;
        end else if (out_free) begin
          emit_en   = 1'b1;
          emit_char = CharZero + {3'b000, top_dig};
          emit_last = last_dig;
          dig_d     = {dig_q[DigW-5:0], 4'd0};
          cnt_d     = cnt_q - 1'b1;
          started_d = 1'b1;
          if (last_dig) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold a result until it is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit_en) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      started_q   <= 1'b0;
      cnt_q       <= '0;
      step_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      started_q   <= started_d;
      cnt_q       <= cnt_d;
      step_q      <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q   <= mag_d;
    dig_q   <= dig_d;
    minus_q <= minus_d;
    if (emit_en) begin
      char_q <= emit_char;
      last_q <= emit_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign ascii_char_o = char_q;
  assign last_o       = last_q;

endmodule

`default_nettype wire

// ----- hdl/integer_to_ascii_radix_core.sv -----
// Top level of the integer-to-ASCII converter: front end, queue, back end.
// Depends on i2a_pkg, i2a_front and i2a_back.
//
//   channel | signals                      | direction
//   --------+------------------------------+----------
//   in      | in_valid/ready, func, value  | sink
//   out     | out_valid/ready, ascii_char, | source
//           | last                         |
//
// Decimal items pass through a load step, the shift-and-add-3 steps, a sign step
// (which also sends a minus sign) and a scan of 22 digit positions, leading zeros
// skipped at one per cycle; octal items skip the shift steps.
// The front queue accepts new items while the back end is busy.
// Reset clears all control state; output stalls hold the back end in place.
`default_nettype none

module integer_to_ascii_radix_core #(
  parameter int QueueDepth = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  func_i,
  input  wire logic [63:0] value_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [6:0]       ascii_char_o,
  output logic             last_o
);
  import i2a_pkg::*;

  work_t work;
  logic  work_valid;
  logic  work_ready;

  i2a_front #(
    .Depth (QueueDepth)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .value_i      (value_i),
    .work_valid_o (work_valid),
    .work_ready_i (work_ready),
    .work_o       (work)
  );

  i2a_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .work_valid_i (work_valid),
    .work_ready_o (work_ready),
    .work_i       (work),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .ascii_char_o (ascii_char_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire

// ----- hdl/i2a_checker.sv -----
// Port-level checks for the integer-to-ASCII converter, bound to the top.
// Depends on i2a_pkg and integer_to_ascii_radix_core_macros.svh.
`default_nettype none

`include "integer_to_ascii_radix_core_macros.svh"

module i2a_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [6:0] ascii_char_o,
  input wire logic       last_o
);
  import i2a_pkg::*;

  // No result is offered while reset is applied
  `I2A_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |-> !out_valid_o, "result valid in reset")

  // A stalled result holds its value
  `I2A_ASSERT(a_out_hold, clk_i, rst_ni,
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(ascii_char_o) && $stable(last_o),
    "stalled result changed")

  // Only digits and the minus sign appear
  `I2A_ASSERT(a_char_set, clk_i, rst_ni,
    out_valid_o |-> (ascii_char_o >= CharZero && ascii_char_o <= CharNine) ||
                    ascii_char_o == CharMinus,
    "illegal character")

  // A minus sign is never the end of the text
  `I2A_ASSERT(a_minus_not_last, clk_i, rst_ni,
    out_valid_o && ascii_char_o == CharMinus |-> !last_o, "minus sign marked last")

endmodule

bind integer_to_ascii_radix_core i2a_checker u_i2a_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .ascii_char_o (ascii_char_o),
  .last_o       (last_o)
);

`default_nettype wire

// ----- tb/integer_to_ascii_radix_checker.sv -----
// Checker for the integer-to-ASCII converter: watches both channels, predicts the text.
// Depends on i2a_pkg for the mode codes and character constants.
module integer_to_ascii_radix_checker
  import i2a_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  func_i,
  input  logic [63:0] value_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [6:0]  ascii_char_i,
  input  logic        last_i,
  output int          mismatch_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             last;
  } text_char_t;

  text_char_t expected_text[$];
  int         mismatches = 0;

  // Append the characters one number should produce, most significant first.
  function automatic void queue_number_text(input func_e mode, input logic [63:0] raw);
    logic [63:0] mag;
    logic [63:0] radix;
    logic [3:0]  digits[NumDigits];
    logic        minus;
    int          nd;
    text_char_t  c;
    radix = (mode == FUNC_OCT) ? 64'd8 : 64'd10;
    minus = (mode == FUNC_SDEC) && raw[63];
    // Negate in 64 bits: the most negative value wraps to magnitude 2^63.
    mag = minus ? -raw : raw;
    nd = 0;
    // Zero still yields one digit.
    do begin
      digits[nd] = 4'(mag % radix);
      mag = mag / radix;
      nd++;
    end while (mag != 64'd0 && nd < NumDigits);
    if (minus) begin
      c.ch = CharMinus;
      c.last = 1'b0;
      expected_text.push_back(c);
    end
    for (int i = nd - 1; i >= 0; i--) begin
      c.ch = CharZero + 7'(digits[i]);
      c.last = (i == 0);
      expected_text.push_back(c);
    end
  endfunction

  // Compare each output transfer with the oldest expectation, then add new ones.
  always @(posedge clk_i) begin
    text_char_t want;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (expected_text.size() == 0) begin
          $display("%0t: unexpected character: expected none, actual char %h last %b",
                   $time, ascii_char_i, last_i);
          mismatches++;
        end else begin
          want = expected_text.pop_front();
          if (want.ch !== ascii_char_i) begin
            $display("%0t: ascii_char mismatch: expected %h, actual %h",
                     $time, want.ch, ascii_char_i);
            mismatches++;
          end
          if (want.last !== last_i) begin
            $display("%0t: last mismatch: expected %b, actual %b", $time, want.last, last_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        queue_number_text(func_e'(func_i), value_i);
      end
    end
    mismatch_count_o <= mismatches;
    pending_o <= expected_text.size();
  end

endmodule

// ----- tb/integer_to_ascii_radix_core_test.sv -----
// Top of the integer-to-ASCII converter testbench: clock, reset, stimulus and verdict.
// Depends on i2a_pkg, integer_to_ascii_radix_core and integer_to_ascii_radix_checker.
module integer_to_ascii_radix_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import i2a_pkg::*;

  localparam int RandomItems = 90;
  localparam int HoldCycles  = 400;
  localparam int DrainCycles = 200;
  localparam int StallLimit  = 5000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  func_d;
  logic [63:0] value_d;
  logic        out_valid;
  logic        out_ready;
  logic [6:0]  ascii_char;
  logic        last_char;
  int          mismatch_count;
  int          pending;
  int          quiet_cycles;
  bit          quiet;
  bit          hold_request;

  always #5 clk_i = ~clk_i;

  integer_to_ascii_radix_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .func_i       (func_d),
    .value_i      (value_d),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .ascii_char_o (ascii_char),
    .last_o       (last_char)
  );

  integer_to_ascii_radix_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .func_i           (func_d),
    .value_i          (value_d),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .ascii_char_i     (ascii_char),
    .last_i           (last_char),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  // Offer one number and hold it until the transfer; idle first at random.
  task automatic send_number(input func_e mode, input logic [63:0] raw);
    while (!quiet && $urandom_range(0, 99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    func_d   <= mode;
    value_d  <= raw;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  // Drop valid and wait until every expected character has come out.
  task automatic drain_text();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Sender: reset, directed numbers, random numbers, verdict.
  initial begin
    func_e       mode;
    logic [63:0] raw;
    quiet = 1'b0;
    hold_request = 1'b0;
    rst_ni   <= 1'b0;
    in_valid <= 1'b0;
    func_d   <= FUNC_UDEC;
    value_d  <= 64'd0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero in every mode, the reserved mode included.
    send_number(FUNC_UDEC, 64'd0);
    send_number(FUNC_OCT, 64'd0);
    send_number(FUNC_SDEC, 64'd0);
    send_number(FUNC_RSVD, 64'd0);
    // Digit boundaries and the widest texts.
    send_number(FUNC_UDEC, 64'd1);
    send_number(FUNC_UDEC, 64'd9);
    send_number(FUNC_UDEC, 64'd10);
    send_number(FUNC_UDEC, 64'd9999999999999999999);
    send_number(FUNC_UDEC, 64'd10000000000000000000);
    send_number(FUNC_UDEC, 64'hFFFF_FFFF_FFFF_FFFF);
    send_number(FUNC_OCT, 64'd7);
    send_number(FUNC_OCT, 64'd8);
    send_number(FUNC_OCT, 64'h8000_0000_0000_0000);
    send_number(FUNC_OCT, 64'hFFFF_FFFF_FFFF_FFFF);
    // Signed: most negative, most positive, minus one and ordinary values.
    send_number(FUNC_SDEC, 64'h8000_0000_0000_0000);
    send_number(FUNC_SDEC, 64'h7FFF_FFFF_FFFF_FFFF);
    send_number(FUNC_SDEC, 64'hFFFF_FFFF_FFFF_FFFF);
    send_number(FUNC_SDEC, -64'd10);
    send_number(FUNC_SDEC, 64'd12345);
    // Reserved mode behaves as unsigned decimal.
    send_number(FUNC_RSVD, 64'hFFFF_FFFF_FFFF_FFFF);
    send_number(FUNC_RSVD, 64'h0123_4567_89AB_CDEF);

    for (int n = 0; n < RandomItems; n++) begin
      // Stall the output for a long stretch so the block backs up.
      if (n == 15) hold_request = 1'b1;
      // Let everything drain once with the input quiet.
      if (n == 50) drain_text();
      quiet = (n >= 65 && n < 95);
      mode = ($urandom_range(0, 99) < 8) ? FUNC_RSVD : func_e'($urandom_range(0, 2));
      raw = {$urandom(), $urandom()};
      case ($urandom_range(0, 4))
        0: ;
        1: raw = raw >> $urandom_range(1, 63);
        2: raw = 64'($urandom_range(0, 1000));
        3: raw = -64'($urandom_range(1, 1000));
        default: raw = (64'd1 << $urandom_range(0, 63)) - 64'($urandom_range(0, 1));
      endcase
      send_number(mode, raw);
    end
    quiet = 1'b0;

    drain_text();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Receiver: random back-pressure, one long hold-off on request.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      out_ready <= quiet || ($urandom_range(0, 99) >= 6);
      @(posedge clk_i);
    end
  end

  // Watchdog: end the run when no transfer happens for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/i2a_pkg.sv
hdl/i2a_front.sv
hdl/i2a_back.sv
hdl/integer_to_ascii_radix_core.sv
hdl/i2a_checker.sv
tb/integer_to_ascii_radix_checker.sv
tb/integer_to_ascii_radix_core_test.sv
